// ----- rtl/dau_pkg.sv -----
// Shared constants, widths and the arctangent table of the dihedral angle unit.
// No dependencies; used by dau_isqrt, dau_cordic and dihedral_angle_unit.
`default_nettype none

package dau_pkg;

  localparam int unsigned COORD_WIDTH     = 24;
  localparam int unsigned ANGLE_FRAC_BITS = 13;
  localparam int unsigned ATAN_ITERATIONS = 16;

  localparam int unsigned ANGLE_W = 16;  // torsion_angle field
  localparam int unsigned BS_W    = 15;  // bond components after common scaling
  localparam int unsigned PROD_W  = 2 * BS_W;
  localparam int unsigned NRM_W   = PROD_W + 1;   // normal components
  localparam int unsigned SQ_W    = PROD_W;       // |b2|^2
  localparam int unsigned SQ_IN_W = SQ_W + 6;     // |b2|^2 * 64
  localparam int unsigned ROOT_W  = SQ_IN_W / 2;
  localparam int unsigned X_W     = 64;
  localparam int unsigned T_W     = 48;
  localparam int unsigned NORM_W  = 31;           // |X|,|Y| < 2^30
  localparam int unsigned CD_W    = 35;           // CORDIC x/y datapath
  localparam int unsigned Z_W     = 34;           // angle accumulator, Q30

  localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // atan(2^-i) truncated to Q30
  function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned i);
    logic signed [Z_W-1:0] res;
    case (i)
      0:       res = 34'sd843314856;
      1:       res = 34'sd497837829;
      2:       res = 34'sd263043836;
      3:       res = 34'sd133525158;
      4:       res = 34'sd67021686;
      5:       res = 34'sd33543515;
      6:       res = 34'sd16775850;
      7:       res = 34'sd8388437;
      8:       res = 34'sd4194282;
      9:       res = 34'sd2097149;
      default: res = (i < 30) ? ((Z_W'(1) << (30 - i)) - Z_W'(1)) : '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dihedral_angle_unit.sv -----
// Top level of the dihedral (torsion) angle unit: vector setup, scaling,
// products, square root, normalization and CORDIC. Uses dau_pkg, dau_isqrt, dau_cordic.
//
//  channel | signals                          | direction | transfer when
//  --------+----------------------------------+-----------+---------------------
//  points  | valid_i, stall_o, p0_x_i..p3_z_i | in        | valid_i && !stall_o
//  angle   | valid_o, stall_i, torsion_angle_o,| out      | valid_o && !stall_i
//          | degenerate_o                     |           |
//
// One item per cycle unless a held result stalls the output; the bit-per-stage square root
// and the CORDIC set the depth of the pipeline.
// The whole pipeline advances on one enable; a stalled result at the output
// freezes every stage, so nothing is dropped or repeated.
// Reset clears the stage valid bits only.
`default_nettype none

module dihedral_angle_unit #(
  parameter int unsigned COORD_WIDTH     = dau_pkg::COORD_WIDTH,
  parameter int unsigned ANGLE_FRAC_BITS = dau_pkg::ANGLE_FRAC_BITS,
  parameter int unsigned ATAN_ITERATIONS = dau_pkg::ATAN_ITERATIONS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  output logic                                   stall_o,
  input  wire logic signed [COORD_WIDTH-1:0]     p0_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     p0_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     p0_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]     p1_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     p1_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     p1_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]     p2_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     p2_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     p2_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]     p3_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     p3_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     p3_z_i,
  output logic                                   valid_o,
  input  wire logic                              stall_i,
  output logic signed [dau_pkg::ANGLE_W-1:0]     torsion_angle_o,
  output logic                                   degenerate_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned MW  = CW + 1;
  localparam int unsigned SW  = $clog2(MW + 1);
  localparam int unsigned BW  = (MW > dau_pkg::BS_W) ? MW : dau_pkg::BS_W;
  localparam int unsigned BSW = dau_pkg::BS_W;
  localparam int unsigned PW  = dau_pkg::PROD_W;
  localparam int unsigned NW  = dau_pkg::NRM_W;
  localparam int unsigned XW  = dau_pkg::X_W;
  localparam int unsigned TW  = dau_pkg::T_W;
  localparam int unsigned RW  = dau_pkg::ROOT_W;
  localparam int unsigned ZW  = dau_pkg::Z_W;
  localparam int unsigned SH  = 30 - ANGLE_FRAC_BITS;
  localparam int unsigned SIDE_W = 1 + XW + TW;

  localparam logic signed [ZW:0] HALF_LSB = (ZW + 1)'(1) <<< (SH - 1);
  localparam logic signed [ZW:0] PIF =
      ((ZW + 1)'(dau_pkg::PI_Q30) + HALF_LSB) >>> SH;

  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // ---- stage 1: bond vectors
  logic signed [CW-1:0] p [12];
  assign p[0]  = p0_x_i;  assign p[1]  = p0_y_i;  assign p[2]  = p0_z_i;
  assign p[3]  = p1_x_i;  assign p[4]  = p1_y_i;  assign p[5]  = p1_z_i;
  assign p[6]  = p2_x_i;  assign p[7]  = p2_y_i;  assign p[8]  = p2_z_i;
  assign p[9]  = p3_x_i;  assign p[10] = p3_y_i;  assign p[11] = p3_z_i;

  logic signed [MW-1:0] b1_q [9];
  logic                 v1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        b1_q[i] <= MW'(p[i+3]) - MW'(p[i]);
      end
    end
  end

  // ---- stage 2: largest magnitude
  logic [MW-1:0]        m_d, m_q;
  logic signed [MW-1:0] b2_q [9];
  logic                 v2_q;

  always_comb begin
    logic [MW-1:0] a;
    m_d = '0;
    for (int i = 0; i < 9; i++) begin
      a = b1_q[i][MW-1] ? MW'(-b1_q[i]) : MW'(b1_q[i]);
      if (a > m_d) m_d = a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q  <= m_d;
      b2_q <= b1_q;
    end
  end

  // ---- stage 3: common scaling to 15-bit components
  logic [SW-1:0]         blen, s_d;
  logic signed [BSW-1:0] bs_d [9];
  logic signed [BSW-1:0] bs_q [9];
  logic                  v3_q;

  always_comb begin
    logic signed [BW-1:0] wide;
    blen = '0;
    for (int j = 0; j < MW; j++) begin
      if (m_q[j]) blen = SW'(j + 1);
    end
    s_d = (blen > SW'(BSW - 1)) ? (blen - SW'(BSW - 1)) : '0;
    for (int i = 0; i < 9; i++) begin
      wide     = BW'(b2_q[i]) >>> s_d;
      bs_d[i]  = wide[BSW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) bs_q <= bs_d;
  end

  // ---- stage 4: cross product terms and squares of b2
  logic signed [PW-1:0]  pr_q [12];
  logic signed [PW-1:0]  sq_q [3];
  logic signed [BSW-1:0] b4_q [3];
  logic                  v4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q[0]  <= bs_q[1] * bs_q[5];
      pr_q[1]  <= bs_q[2] * bs_q[4];
      pr_q[2]  <= bs_q[2] * bs_q[3];
      pr_q[3]  <= bs_q[0] * bs_q[5];
      pr_q[4]  <= bs_q[0] * bs_q[4];
      pr_q[5]  <= bs_q[1] * bs_q[3];
      pr_q[6]  <= bs_q[4] * bs_q[8];
      pr_q[7]  <= bs_q[5] * bs_q[7];
      pr_q[8]  <= bs_q[5] * bs_q[6];
      pr_q[9]  <= bs_q[3] * bs_q[8];
      pr_q[10] <= bs_q[3] * bs_q[7];
      pr_q[11] <= bs_q[4] * bs_q[6];
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= bs_q[i+3] * bs_q[i+3];
        b4_q[i] <= bs_q[i];
      end
    end
  end

  // ---- stage 5: normals n1, n2 and |b2|^2
  logic signed [NW-1:0]    n1_q [3];
  logic signed [NW-1:0]    n2_q [3];
  logic [dau_pkg::SQ_W-1:0] b2sq5_q;
  logic signed [BSW-1:0]   b5_q [3];
  logic                    v5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n1_q[i] <= NW'(pr_q[2*i]) - NW'(pr_q[2*i+1]);
        n2_q[i] <= NW'(pr_q[2*i+6]) - NW'(pr_q[2*i+7]);
      end
      b2sq5_q <= dau_pkg::SQ_W'($unsigned(sq_q[0]) + $unsigned(sq_q[1])
                                + $unsigned(sq_q[2]));
      b5_q    <= b4_q;
    end
  end

  // ---- stage 6: dot product terms, degenerate test
  logic signed [2*NW-1:0]   xp_q [3];
  logic signed [BSW+NW-1:0] tp_q [3];
  logic [dau_pkg::SQ_W-1:0] b2sq6_q;
  logic                     deg6_q;
  logic                     v6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        xp_q[i] <= n1_q[i] * n2_q[i];
        tp_q[i] <= b5_q[i] * n2_q[i];
      end
      b2sq6_q <= b2sq5_q;
      deg6_q  <= (n1_q[0] == '0 && n1_q[1] == '0 && n1_q[2] == '0) ||
                 (n2_q[0] == '0 && n2_q[1] == '0 && n2_q[2] == '0);
    end
  end

  // ---- stage 7: x = n1.n2, t = b1.n2
  logic signed [XW-1:0]     x7_q;
  logic signed [TW-1:0]     t7_q;
  logic [dau_pkg::SQ_W-1:0] b2sq7_q;
  logic                     deg7_q;
  logic                     v7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x7_q    <= XW'(xp_q[0]) + XW'(xp_q[1]) + XW'(xp_q[2]);
      t7_q    <= TW'(tp_q[0]) + TW'(tp_q[1]) + TW'(tp_q[2]);
      b2sq7_q <= b2sq6_q;
      deg7_q  <= deg6_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  // ---- |b2| in Q.3
  logic              sq_vld;
  logic [RW-1:0]     root;
  logic [SIDE_W-1:0] sq_side;

  dau_isqrt #(
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v7_q),
    .val_i  ({b2sq7_q, 6'b0}),
    .side_i ({deg7_q, x7_q, t7_q}),
    .vld_o  (sq_vld),
    .root_o (root),
    .side_o (sq_side)
  );

  logic                 sq_deg;
  logic signed [XW-1:0] sq_x;
  logic signed [TW-1:0] sq_t;
  assign sq_deg = sq_side[SIDE_W-1];
  assign sq_x   = sq_side[XW+TW-1:TW];
  assign sq_t   = sq_side[TW-1:0];

  // ---- Y = r*t in two partial products, X = -8x
  localparam int unsigned LO_W = TW / 2;
  logic [RW+LO_W-1:0]          lo_q;
  logic signed [RW+LO_W:0]     hi_q;
  logic signed [XW-1:0]        xa_q, xb_q, yb_q;
  logic                        dega_q, degb_q, va_q, vb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lo_q   <= (RW + LO_W)'(root) * (RW + LO_W)'(sq_t[LO_W-1:0]);
      hi_q   <= $signed({1'b0, root}) * $signed(sq_t[TW-1:LO_W]);
      xa_q   <= -(sq_x <<< 3);
      dega_q <= sq_deg;
      yb_q   <= (XW'(hi_q) <<< LO_W) + XW'(lo_q);
      xb_q   <= xa_q;
      degb_q <= dega_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= sq_vld;
      vb_q <= va_q;
    end
  end

  // ---- common right shift until both fit in (-2^30, 2^30), one shift size per stage
  localparam int unsigned NSTG = 6;
  localparam logic signed [XW-1:0] LIM = XW'(64'sd1073741824);

  logic signed [XW-1:0] nx_q [NSTG];
  logic signed [XW-1:0] ny_q [NSTG];
  logic                 nd_q [NSTG];
  logic                 nv_q [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_norm
    localparam int unsigned STEP = 32 >> g;
    logic signed [XW-1:0] x_in, y_in, wx, wy;
    logic                 d_in, v_in, fits;

    if (g == 0) begin : g_first
      assign x_in = xb_q;
      assign y_in = yb_q;
      assign d_in = degb_q;
      assign v_in = vb_q;
    end else begin : g_next
      assign x_in = nx_q[g-1];
      assign y_in = ny_q[g-1];
      assign d_in = nd_q[g-1];
      assign v_in = nv_q[g-1];
    end

    assign wx   = x_in >>> (STEP - 1);
    assign wy   = y_in >>> (STEP - 1);
    assign fits = (wx < LIM) && (wx > -LIM) && (wy < LIM) && (wy > -LIM);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[g] <= 1'b0;
      end else if (en) begin
        nv_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        nx_q[g] <= fits ? x_in : (x_in >>> STEP);
        ny_q[g] <= fits ? y_in : (y_in >>> STEP);
        nd_q[g] <= d_in;
      end
    end
  end

  // ---- CORDIC
  logic                 cd_vld, cd_deg;
  logic signed [ZW-1:0] cd_z;

  dau_cordic #(
    .ITER   (ATAN_ITERATIONS),
    .SIDE_W (1)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (nv_q[NSTG-1]),
    .x_i    (nx_q[NSTG-1][dau_pkg::NORM_W-1:0]),
    .y_i    (ny_q[NSTG-1][dau_pkg::NORM_W-1:0]),
    .side_i (nd_q[NSTG-1]),
    .vld_o  (cd_vld),
    .z_o    (cd_z),
    .side_o (cd_deg)
  );

  // ---- rounding, range fold and output register
  logic signed [ZW:0] rnd, ang;
  logic               out_vld_q, out_deg_q;
  logic signed [dau_pkg::ANGLE_W-1:0] out_ang_q;

  always_comb begin
    rnd = ((ZW + 1)'(cd_z) + HALF_LSB) >>> SH;
    ang = rnd;
    if (rnd > PIF || rnd <= -PIF) ang = PIF;
    if (cd_deg) ang = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= cd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_ang_q <= ang[dau_pkg::ANGLE_W-1:0];
      out_deg_q <= cd_deg;
    end
  end

  assign valid_o         = out_vld_q;
  assign torsion_angle_o = out_ang_q;
  assign degenerate_o    = out_deg_q;

  // ---- checks
  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && degenerate_o) |-> (torsion_angle_o == '0))
    else $error("degenerate result with nonzero angle");

  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled without a held result");

  a_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v7_q && stall_o) |=> (v7_q && $stable(x7_q) && $stable(t7_q)))
    else $error("pipeline moved during a stall");

  if (ANGLE_FRAC_BITS <= 13) begin : g_range_chk
    a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_o |-> ((ZW + 1)'(torsion_angle_o) <= PIF &&
                   (ZW + 1)'(torsion_angle_o) > -PIF))
      else $error("angle outside (-pi, pi]");
  end

endmodule

`default_nettype wire

// ----- rtl/dau_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a sideband.
// Depends on dau_pkg for the operand width.
`default_nettype none

module dau_isqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              vld_i,
  input  wire logic [dau_pkg::SQ_IN_W-1:0]       val_i,
  input  wire logic [SIDE_W-1:0]                 side_i,
  output logic                                   vld_o,
  output logic [dau_pkg::ROOT_W-1:0]             root_o,
  output logic [SIDE_W-1:0]                      side_o
);

  localparam int unsigned IN_W = dau_pkg::SQ_IN_W;
  localparam int unsigned ITER = IN_W / 2;
  localparam int unsigned RW   = IN_W + 1;

  logic [RW-1:0]     rem_q  [ITER];
  logic [RW-1:0]     res_q  [ITER];
  logic              vld_q  [ITER];
  logic [SIDE_W-1:0] side_q [ITER];

  for (genvar g = 0; g < ITER; g++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (IN_W - 2 - 2 * g);
    logic [RW-1:0]     rem_in, res_in, sum, rem_d, res_d;
    logic              vld_in;
    logic [SIDE_W-1:0] side_in;

    if (g == 0) begin : g_first
      assign rem_in  = RW'(val_i);
      assign res_in  = '0;
      assign vld_in  = vld_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign res_in  = res_q[g-1];
      assign vld_in  = vld_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin
      sum = res_in + BIT;
      if (rem_in >= sum) begin
        rem_d = rem_in - sum;
        res_d = (res_in >> 1) + BIT;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        res_q[g]  <= res_d;
        side_q[g] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[ITER-1];
  assign root_o = res_q[ITER-1][dau_pkg::ROOT_W-1:0];
  assign side_o = side_q[ITER-1];

endmodule

`default_nettype wire

// ----- rtl/dau_cordic.sv -----
// Vectoring CORDIC: quadrant fold, then one micro-rotation per stage.
// Depends on dau_pkg for widths and the arctangent table.
`default_nettype none

module dau_cordic #(
  parameter int unsigned ITER   = dau_pkg::ATAN_ITERATIONS,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                vld_i,
  input  wire logic signed [dau_pkg::NORM_W-1:0]   x_i,
  input  wire logic signed [dau_pkg::NORM_W-1:0]   y_i,
  input  wire logic [SIDE_W-1:0]                   side_i,
  output logic                                     vld_o,
  output logic signed [dau_pkg::Z_W-1:0]           z_o,
  output logic [SIDE_W-1:0]                        side_o
);

  localparam int unsigned W  = dau_pkg::CD_W;
  localparam int unsigned ZW = dau_pkg::Z_W;

  logic signed [W-1:0]  fx_d, fy_d, fx_q, fy_q;
  logic signed [ZW-1:0] fz_d, fz_q;
  logic                 fv_q;
  logic [SIDE_W-1:0]    fs_q;

  // fold into the right half plane
  always_comb begin
    fx_d = W'(x_i);
    fy_d = W'(y_i);
    fz_d = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        fx_d = W'(y_i);
        fy_d = -W'(x_i);
        fz_d = dau_pkg::HALF_PI_Q30;
      end else begin
        fx_d = -W'(y_i);
        fy_d = W'(x_i);
        fz_d = -dau_pkg::HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (en_i) begin
      fv_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx_q <= fx_d;
      fy_q <= fy_d;
      fz_q <= fz_d;
      fs_q <= side_i;
    end
  end

  logic signed [W-1:0]  x_q [ITER];
  logic signed [W-1:0]  y_q [ITER];
  logic signed [ZW-1:0] z_q [ITER];
  logic                 v_q [ITER];
  logic [SIDE_W-1:0]    s_q [ITER];

  for (genvar g = 0; g < ITER; g++) begin : g_rot
    localparam logic signed [ZW-1:0] ANG = dau_pkg::atan_entry(g);
    logic signed [W-1:0]  x_in, y_in, x_d, y_d;
    logic signed [ZW-1:0] z_in, z_d;
    logic                 v_in;
    logic [SIDE_W-1:0]    s_in;

    if (g == 0) begin : g_first
      assign x_in = fx_q;
      assign y_in = fy_q;
      assign z_in = fz_q;
      assign v_in = fv_q;
      assign s_in = fs_q;
    end else begin : g_next
      assign x_in = x_q[g-1];
      assign y_in = y_q[g-1];
      assign z_in = z_q[g-1];
      assign v_in = v_q[g-1];
      assign s_in = s_q[g-1];
    end

    always_comb begin
      if (y_in >= 0) begin
        x_d = x_in + (y_in >>> g);
        y_d = y_in - (x_in >>> g);
        z_d = z_in + ANG;
      end else begin
        x_d = x_in - (y_in >>> g);
        y_d = y_in + (x_in >>> g);
        z_d = z_in - ANG;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g] <= x_d;
        y_q[g] <= y_d;
        z_q[g] <= z_d;
        s_q[g] <= s_in;
      end
    end
  end

  assign vld_o  = v_q[ITER-1];
  assign z_o    = z_q[ITER-1];
  assign side_o = s_q[ITER-1];

endmodule

`default_nettype wire
